FILE: rtl/core/tppg_pkg.sv
// Shared types and constants for the trigger pulse pattern generator.
// Used by tppg_sequencer and trigger_pulse_pattern_generator; no dependencies.
package tppg_pkg;

    // Configuration register field width and index width.
    localparam int CFG_DATA_BITS  = 20;
    localparam int CFG_INDEX_BITS = 3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_BURST_MODE        = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SINGLE_WIDTH      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAP_LENGTH        = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_GAP_LENGTH  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLOPE_HALF_PERIOD = 3'd4;

    // Register reset values.
    localparam logic                     BURST_MODE_RESET        = 1'b1;
    localparam logic [CFG_DATA_BITS-1:0] SINGLE_WIDTH_RESET      = 20'd50;
    localparam logic [CFG_DATA_BITS-1:0] GAP_LENGTH_RESET        = 20'd2000;
    localparam logic [CFG_DATA_BITS-1:0] FRAME_GAP_LENGTH_RESET  = 20'd20000;
    localparam logic [CFG_DATA_BITS-1:0] SLOPE_HALF_PERIOD_RESET = 20'd5000;

    // The marker lasts a fixed number of ticks.
    localparam int MARKER_TICKS = 5;

    // Burst pulse widths fit in this many bits.
    localparam int BURST_WIDTH_BITS = 11;

    // Configuration values seen by the phase sequencer.
    typedef struct packed {
        logic                     burst_mode;
        logic [CFG_DATA_BITS-1:0] single_width;
        logic [CFG_DATA_BITS-1:0] gap_length;
        logic [CFG_DATA_BITS-1:0] frame_gap_length;
    } seq_cfg_t;

    // Levels of the current tick as seen by the top level.
    typedef struct packed {
        logic direct;
        logic marker;
        logic marker_first;
    } seq_status_t;

    // Width of each of the four burst pulses, in ticks.
    function automatic logic [BURST_WIDTH_BITS-1:0] burst_width(input logic [1:0] idx);
        logic [BURST_WIDTH_BITS-1:0] w;
        begin
            case (idx)
                2'd0:    w = 11'd10;
                2'd1:    w = 11'd50;
                2'd2:    w = 11'd100;
                default: w = 11'd1000;
            endcase
            return w;
        end
    endfunction

endpackage

FILE: rtl/core/tppg_sequencer.sv
// Frame phase sequencer: marker, direct pulses, gaps and frame gap.
// Depends on tppg_pkg for the configuration struct and burst widths.
module tppg_sequencer
    import tppg_pkg::*;
#(
    parameter int COUNT_BITS = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  seq_cfg_t    cfg,
    output seq_status_t status
);

    typedef enum logic [1:0] {
        PH_MARKER = 2'd0,
        PH_PULSE  = 2'd1,
        PH_GAP    = 2'd2,
        PH_FRAME  = 2'd3
    } phase_t;

    localparam logic [COUNT_BITS-1:0] MARKER_COUNT = COUNT_BITS'(MARKER_TICKS);
    localparam logic [COUNT_BITS-1:0] ONE          = COUNT_BITS'(1);

    phase_t                phase_reg, phase_next;
    logic [COUNT_BITS-1:0] remaining_reg, remaining_next;
    logic [1:0]            burst_index_reg, burst_index_next;
    logic                  frame_is_burst_reg, frame_is_burst_next;

    logic [COUNT_BITS-1:0] single_len;
    logic [COUNT_BITS-1:0] gap_len;
    logic [COUNT_BITS-1:0] frame_gap_len;
    logic [COUNT_BITS-1:0] first_burst_len;
    logic [COUNT_BITS-1:0] next_burst_len;

    // A length of zero behaves as one tick.
    function automatic logic [COUNT_BITS-1:0] at_least_one(input logic [CFG_DATA_BITS-1:0] v);
        logic [COUNT_BITS-1:0] c;
        begin
            c = COUNT_BITS'(v);
            return (c == '0) ? ONE : c;
        end
    endfunction

    assign single_len      = at_least_one(cfg.single_width);
    assign gap_len         = at_least_one(cfg.gap_length);
    assign frame_gap_len   = at_least_one(cfg.frame_gap_length);
    assign first_burst_len = COUNT_BITS'(burst_width(2'd0));
    assign next_burst_len  = COUNT_BITS'(burst_width(burst_index_reg + 2'd1));

    // Levels of the current tick, before it advances the state.
    assign status.direct       = (phase_reg == PH_PULSE);
    assign status.marker       = (phase_reg == PH_MARKER);
    assign status.marker_first = (phase_reg == PH_MARKER) && (remaining_reg == MARKER_COUNT);

    // Next phase: count down, and load the following phase's length at the end.
    always_comb
    begin
        phase_next          = phase_reg;
        remaining_next      = remaining_reg;
        burst_index_next    = burst_index_reg;
        frame_is_burst_next = frame_is_burst_reg;
        if (remaining_reg > ONE)
        begin
            remaining_next = remaining_reg - ONE;
        end
        else
        begin
            unique case (phase_reg)
                PH_MARKER:
                begin
                    frame_is_burst_next = cfg.burst_mode;
                    burst_index_next    = 2'd0;
                    phase_next          = PH_PULSE;
                    remaining_next      = cfg.burst_mode ? first_burst_len : single_len;
                end
                PH_PULSE:
                begin
                    if (frame_is_burst_reg)
                    begin
                        phase_next     = PH_GAP;
                        remaining_next = gap_len;
                    end
                    else
                    begin
                        phase_next     = PH_FRAME;
                        remaining_next = frame_gap_len;
                    end
                end
                PH_GAP:
                begin
                    if (burst_index_reg == 2'd3)
                    begin
                        phase_next     = PH_FRAME;
                        remaining_next = frame_gap_len;
                    end
                    else
                    begin
                        burst_index_next = burst_index_reg + 2'd1;
                        phase_next       = PH_PULSE;
                        remaining_next   = next_burst_len;
                    end
                end
                default:
                begin
                    phase_next       = PH_MARKER;
                    remaining_next   = MARKER_COUNT;
                    burst_index_next = 2'd0;
                end
            endcase
        end
    end

    // Phase state advances only on an accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_MARKER;
            remaining_reg      <= MARKER_COUNT;
            burst_index_reg    <= 2'd0;
            frame_is_burst_reg <= 1'b1;
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            remaining_reg      <= remaining_next;
            burst_index_reg    <= burst_index_next;
            frame_is_burst_reg <= frame_is_burst_next;
        end
    end

endmodule

FILE: rtl/core/trigger_pulse_pattern_generator.sv
// Top level of the trigger pulse pattern generator.
// Depends on tppg_pkg and tppg_sequencer.
//
// Usage: each input beat carries one tick bit; a beat with tick high advances
// time by one microsecond, a beat with tick low only reports the held levels.
// Every input beat yields exactly one output beat with direct_level,
// marker_level, slope_level and frame_start for that beat, taken before the
// tick advances the state. A beat is accepted when in_valid is high and
// in_stall is low; a result is taken when out_valid is high and out_stall low.
// A beat's result is in the output register in the cycle after acceptance, and
// one beat is accepted every cycle unless the receiver stalls, since the state
// update and level decode fit between the state registers and the single output
// register. When the receiver stalls, the output register holds its beat and
// in_stall rises, so no new beat enters until the waiting result is taken.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high and a write is taken in the cycle it is offered.
// Reset starts a frame at the first marker tick in burst mode, with the square
// wave low and all registers at their documented defaults.
module trigger_pulse_pattern_generator
    import tppg_pkg::*;
#(
    parameter int COUNT_BITS = 20
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      tick,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      direct_level,
    output logic                      marker_level,
    output logic                      slope_level,
    output logic                      frame_start,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam logic [COUNT_BITS-1:0] ONE = COUNT_BITS'(1);

    logic                     burst_mode_reg;
    logic [CFG_DATA_BITS-1:0] single_width_reg;
    logic [CFG_DATA_BITS-1:0] gap_length_reg;
    logic [CFG_DATA_BITS-1:0] frame_gap_length_reg;
    logic [CFG_DATA_BITS-1:0] slope_half_period_reg;

    logic                  slope_state_reg, slope_state_next;
    logic [COUNT_BITS-1:0] slope_count_reg, slope_count_next;
    logic [COUNT_BITS-1:0] slope_inc;
    logic [COUNT_BITS-1:0] slope_half;

    logic out_valid_reg;
    logic direct_reg, marker_reg, slope_reg, frame_start_reg;

    logic        accept;
    logic        advance;
    seq_cfg_t    seq_cfg;
    seq_status_t seq_status;

    // Handshake: take a new beat whenever the output register is free or drains.
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign advance   = accept && tick;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_mode_reg        <= BURST_MODE_RESET;
            single_width_reg      <= SINGLE_WIDTH_RESET;
            gap_length_reg        <= GAP_LENGTH_RESET;
            frame_gap_length_reg  <= FRAME_GAP_LENGTH_RESET;
            slope_half_period_reg <= SLOPE_HALF_PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BURST_MODE:        burst_mode_reg        <= cfg_data[0];
                REG_SINGLE_WIDTH:      single_width_reg      <= cfg_data;
                REG_GAP_LENGTH:        gap_length_reg        <= cfg_data;
                REG_FRAME_GAP_LENGTH:  frame_gap_length_reg  <= cfg_data;
                REG_SLOPE_HALF_PERIOD: slope_half_period_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    assign seq_cfg.burst_mode       = burst_mode_reg;
    assign seq_cfg.single_width     = single_width_reg;
    assign seq_cfg.gap_length       = gap_length_reg;
    assign seq_cfg.frame_gap_length = frame_gap_length_reg;

    tppg_sequencer #(
        .COUNT_BITS (COUNT_BITS)
    ) u_sequencer (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cfg     (seq_cfg),
        .status  (seq_status)
    );

    // Square wave: toggle when the count reaches or passes the half period or wraps.
    assign slope_half = (COUNT_BITS'(slope_half_period_reg) == '0)
                        ? ONE : COUNT_BITS'(slope_half_period_reg);
    assign slope_inc  = slope_count_reg + ONE;

    always_comb
    begin
        slope_state_next = slope_state_reg;
        slope_count_next = slope_inc;
        if ((slope_inc >= slope_half) || (slope_inc == '0))
        begin
            slope_state_next = !slope_state_reg;
            slope_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_state_reg <= 1'b0;
            slope_count_reg <= '0;
        end
        else if (advance)
        begin
            slope_state_reg <= slope_state_next;
            slope_count_reg <= slope_count_next;
        end
    end

    // Output register holds the levels of the accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            direct_reg      <= seq_status.direct;
            marker_reg      <= seq_status.marker;
            slope_reg       <= slope_state_reg;
            frame_start_reg <= tick && seq_status.marker_first;
        end
    end

    assign out_valid    = out_valid_reg;
    assign direct_level = direct_reg;
    assign marker_level = marker_reg;
    assign slope_level  = slope_reg;
    assign frame_start  = frame_start_reg;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for trigger_pulse_pattern_generator.
// It predicts the marker, direct, square wave and frame start levels of every beat.
// Depends on tppg_pkg and the RTL of the generator; it reads no files.
module tb_top;
    import tppg_pkg::*;

    localparam int COUNT_BITS     = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 60;

    // Phases of one frame as tracked by the predictor.
    typedef enum logic [1:0] {
        SEQ_MARKER    = 2'd0,
        SEQ_PULSE     = 2'd1,
        SEQ_GAP       = 2'd2,
        SEQ_FRAME_GAP = 2'd3
    } seq_phase_t;

    // Levels carried by one result beat.
    typedef struct packed {
        logic direct;
        logic marker;
        logic slope;
        logic first;
    } levels_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic tick = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic direct_level;
    logic marker_level;
    logic slope_level;
    logic frame_start;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // Register copies held by the predictor.
    logic                     cfg_burst_sel       = BURST_MODE_RESET;
    logic [CFG_DATA_BITS-1:0] cfg_single_ticks    = SINGLE_WIDTH_RESET;
    logic [CFG_DATA_BITS-1:0] cfg_gap_ticks       = GAP_LENGTH_RESET;
    logic [CFG_DATA_BITS-1:0] cfg_frame_gap_ticks = FRAME_GAP_LENGTH_RESET;
    logic [CFG_DATA_BITS-1:0] cfg_slope_half      = SLOPE_HALF_PERIOD_RESET;

    // Sequencer state held by the predictor.
    seq_phase_t            seq_phase       = SEQ_MARKER;
    logic [COUNT_BITS-1:0] seq_left        = COUNT_BITS'(MARKER_TICKS);
    logic [1:0]            seq_burst_idx   = 2'd0;
    logic [COUNT_BITS-1:0] seq_slope_count = '0;
    logic                  seq_slope       = 1'b0;
    logic                  seq_frame_burst = 1'b1;
    logic [10:0]           burst_len [4]   = '{11'd10, 11'd50, 11'd100, 11'd1000};

    levels_t expected_levels[$];

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int fail_count = 0;
    int beats_sent = 0;
    int results_checked = 0;
    int frames_predicted = 0;
    int reg_writes = 0;
    int quiet_cycles = 0;

    trigger_pulse_pattern_generator #(
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .tick(tick),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .direct_level(direct_level),
        .marker_level(marker_level),
        .slope_level(slope_level),
        .frame_start(frame_start),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // A register value of zero stretches to one tick.
    function automatic logic [COUNT_BITS-1:0] at_least_one(input logic [CFG_DATA_BITS-1:0] v);
        return (v == '0) ? COUNT_BITS'(1) : COUNT_BITS'(v);
    endfunction

    // Levels seen during this beat, then the advance of one tick if there is one.
    function automatic levels_t step_sequence(input logic t);
        levels_t lv;
        logic [COUNT_BITS-1:0] next_count;
        lv.direct = (seq_phase == SEQ_PULSE);
        lv.marker = (seq_phase == SEQ_MARKER);
        lv.slope  = seq_slope;
        lv.first  = t && (seq_phase == SEQ_MARKER) && (seq_left == COUNT_BITS'(MARKER_TICKS));
        if (t)
        begin
            next_count = seq_slope_count + COUNT_BITS'(1);
            if (next_count >= at_least_one(cfg_slope_half) || next_count == '0)
            begin
                seq_slope = ~seq_slope;
                seq_slope_count = '0;
            end
            else
            begin
                seq_slope_count = next_count;
            end
            if (seq_left > COUNT_BITS'(1))
            begin
                seq_left = seq_left - COUNT_BITS'(1);
            end
            else
            begin
                case (seq_phase)
                    SEQ_MARKER:
                    begin
                        seq_frame_burst = cfg_burst_sel;
                        seq_burst_idx = 2'd0;
                        seq_phase = SEQ_PULSE;
                        seq_left = seq_frame_burst ? COUNT_BITS'(burst_len[0])
                                                   : at_least_one(cfg_single_ticks);
                    end
                    SEQ_PULSE:
                    begin
                        if (seq_frame_burst)
                        begin
                            seq_phase = SEQ_GAP;
                            seq_left = at_least_one(cfg_gap_ticks);
                        end
                        else
                        begin
                            seq_phase = SEQ_FRAME_GAP;
                            seq_left = at_least_one(cfg_frame_gap_ticks);
                        end
                    end
                    SEQ_GAP:
                    begin
                        if (seq_burst_idx == 2'd3)
                        begin
                            seq_phase = SEQ_FRAME_GAP;
                            seq_left = at_least_one(cfg_frame_gap_ticks);
                        end
                        else
                        begin
                            seq_burst_idx = seq_burst_idx + 2'd1;
                            seq_phase = SEQ_PULSE;
                            seq_left = COUNT_BITS'(burst_len[seq_burst_idx]);
                        end
                    end
                    default:
                    begin
                        seq_phase = SEQ_MARKER;
                        seq_left = COUNT_BITS'(MARKER_TICKS);
                        seq_burst_idx = 2'd0;
                    end
                endcase
            end
        end
        return lv;
    endfunction

    // Offer one tick beat, with random idle cycles first. Called and returns at a falling edge.
    task automatic send_beat(input logic t);
        levels_t lv;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            tick <= 1'($urandom_range(1));
            @(negedge clk);
        end
        in_valid <= 1'b1;
        tick <= t;
        do
            @(posedge clk);
        while (in_stall);
        lv = step_sequence(t);
        if (lv.first)
            frames_predicted++;
        expected_levels.push_back(lv);
        beats_sent++;
        @(negedge clk);
    endtask

    // Stop offering beats and wait until every predicted result has been checked.
    task automatic wait_results_drained;
        in_valid <= 1'b0;
        while (expected_levels.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // Write one register while the block is idle; the valid then drops before the task returns.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_BURST_MODE:        cfg_burst_sel = data[0];
            REG_SINGLE_WIDTH:      cfg_single_ticks = data;
            REG_GAP_LENGTH:        cfg_gap_ticks = data;
            REG_FRAME_GAP_LENGTH:  cfg_frame_gap_ticks = data;
            REG_SLOPE_HALF_PERIOD: cfg_slope_half = data;
            default:               ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Reset values: a held beat reports levels without a frame start, the first tick has one.
    task automatic test_reset_levels;
        send_beat(1'b0);
        send_beat(1'b1);
        send_beat(1'b0);
    endtask

    // Zero in every length register acts as one tick, so a frame is only a few ticks long.
    task automatic test_zero_lengths;
        wait_results_drained();
        write_reg(REG_BURST_MODE, '0);
        write_reg(REG_SINGLE_WIDTH, '0);
        write_reg(REG_GAP_LENGTH, '0);
        write_reg(REG_FRAME_GAP_LENGTH, '0);
        write_reg(REG_SLOPE_HALF_PERIOD, '0);
        repeat (12) send_beat(1'b1);
    endtask

    // Shrinking the half period below the running count toggles the wave on the next tick.
    task automatic test_slope_retune;
        wait_results_drained();
        write_reg(REG_SLOPE_HALF_PERIOD, 20'd8);
        repeat (5) send_beat(1'b1);
        wait_results_drained();
        write_reg(REG_SLOPE_HALF_PERIOD, 20'd2);
        repeat (3) send_beat(1'b1);
    endtask

    // Short single-pulse frames with random lengths and random tick gaps.
    task automatic test_random_frames(input int idle, input int stall, input int count);
        wait_results_drained();
        idle_pct = idle;
        stall_pct = stall;
        write_reg(REG_BURST_MODE, '0);
        write_reg(REG_SINGLE_WIDTH, CFG_DATA_BITS'($urandom_range(12)));
        write_reg(REG_GAP_LENGTH, CFG_DATA_BITS'($urandom_range(12)));
        write_reg(REG_FRAME_GAP_LENGTH, CFG_DATA_BITS'($urandom_range(12)));
        write_reg(REG_SLOPE_HALF_PERIOD, CFG_DATA_BITS'($urandom_range(24)));
        repeat (count) send_beat($urandom_range(99) < 80);
    endtask

    // One full burst frame. During the longest pulse the length registers go to their
    // maximum and back, and burst mode is dropped; the running frame must not notice.
    task automatic test_burst_frame;
        int frames_at_start;
        bit extremes_done;
        wait_results_drained();
        idle_pct = 18;
        stall_pct = 18;
        write_reg(REG_BURST_MODE, 20'd1);
        write_reg(REG_GAP_LENGTH, CFG_DATA_BITS'($urandom_range(1, 6)));
        write_reg(REG_FRAME_GAP_LENGTH, CFG_DATA_BITS'($urandom_range(1, 10)));
        write_reg(REG_SLOPE_HALF_PERIOD, CFG_DATA_BITS'($urandom_range(20, 60)));
        frames_at_start = frames_predicted;
        extremes_done = 1'b0;
        while (frames_predicted < frames_at_start + 2)
        begin
            send_beat($urandom_range(99) < 95);
            if (!extremes_done && seq_phase == SEQ_PULSE && seq_burst_idx == 2'd3
                && seq_left > COUNT_BITS'(100))
            begin
                extremes_done = 1'b1;
                wait_results_drained();
                write_reg(REG_SINGLE_WIDTH, 20'hFFFFF);
                write_reg(REG_GAP_LENGTH, 20'hFFFFF);
                write_reg(REG_FRAME_GAP_LENGTH, 20'hFFFFF);
                write_reg(REG_SLOPE_HALF_PERIOD, 20'hFFFFF);
                write_reg(REG_BURST_MODE, '0);
                repeat (10) send_beat(1'b1);
                wait_results_drained();
                write_reg(REG_SINGLE_WIDTH, CFG_DATA_BITS'($urandom_range(1, 12)));
                write_reg(REG_GAP_LENGTH, CFG_DATA_BITS'($urandom_range(1, 6)));
                write_reg(REG_FRAME_GAP_LENGTH, CFG_DATA_BITS'($urandom_range(1, 10)));
                write_reg(REG_SLOPE_HALF_PERIOD, CFG_DATA_BITS'($urandom_range(1, 8)));
            end
        end
    endtask

    // The receiver holds off for a long stretch while beats keep coming, so the input stalls.
    task automatic test_backpressure;
        wait_results_drained();
        idle_pct = 0;
        stall_pct = 0;
        hold_requests++;
        repeat (80) send_beat($urandom_range(99) < 80);
    endtask

    // Receiver: random stalls, or a long hold when one is requested.
    always @(negedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Compare each result beat with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        levels_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_levels.size() == 0)
            begin
                $error("Result beat arrived with no prediction waiting");
                fail_count++;
            end
            else
            begin
                want = expected_levels.pop_front();
                results_checked++;
                if (direct_level !== want.direct)
                begin
                    $error("direct_level: expected %0b, got %0b", want.direct, direct_level);
                    fail_count++;
                end
                if (marker_level !== want.marker)
                begin
                    $error("marker_level: expected %0b, got %0b", want.marker, marker_level);
                    fail_count++;
                end
                if (slope_level !== want.slope)
                begin
                    $error("slope_level: expected %0b, got %0b", want.slope, slope_level);
                    fail_count++;
                end
                if (frame_start !== want.first)
                begin
                    $error("frame_start: expected %0b, got %0b", want.first, frame_start);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too many cycles without any beat or register write moving ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_levels();
        test_zero_lengths();
        test_slope_retune();
        test_random_frames(0, 0, 60);
        test_random_frames(46, 0, 60);
        test_random_frames(0, 46, 60);
        test_random_frames(18, 18, 60);
        test_burst_frame();
        test_backpressure();

        wait_results_drained();
        repeat (5) @(posedge clk);
        $display("Covered %0d tick beats, %0d checked results and %0d frames,",
                 beats_sent, results_checked, frames_predicted);
        $display("with %0d register writes over idle, stall, burst and backpressure phases.",
                 reg_writes);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
